// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the slot allocator RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define FSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define FSA_NEVER(lbl, cond, msg) \
  `FSA_ASSERT(lbl, !(cond), msg)

`endif

// ----- hw/rtl/fsa_pkg.sv -----
// Shared types and constants of the free-list slot allocator.
// No dependencies; used by free_list_slot_allocator_core and the testbench.
package fsa_pkg;

  localparam int unsigned POOL_SLOTS_DEF = 1024;
  localparam int unsigned SLOT_W         = 10;
  localparam int unsigned CNT_W          = 11;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned IN_TDATA_W     = 16;
  localparam int unsigned OUT_TDATA_W    = 40;
  localparam logic [CNT_W-1:0] LIMIT_RST = 11'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_RESTART   = 3'd2,
    CMD_WALK_INIT = 3'd3,
    CMD_WALK_NEXT = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_OUT_OF_SLOTS = 2'd1,
    ST_WALK_END     = 2'd2
  } status_e;

endpackage

// ----- hw/rtl/fsa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the allocator's link memory.
module fsa_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/free_list_slot_allocator_core.sv -----
// Free-list slot allocator: hands out slot indices from a pool, one command per beat.
// Depends on fsa_pkg, fsa_ram and assert_macros.svh.
//
// Commands arrive on the slave stream: allocate pops the most recently freed slot
// from a LIFO free stack (linked through a link RAM) or, with the stack empty, takes
// the next never-used slot from a bump pointer; free pushes a slot; restart empties
// the pool; traversal init/next walk every slot ever handed out fresh. Each command
// yields exactly one result beat carrying the slot, a status and both counts after
// the command. The block takes one command per clock unless the result stream stalls.
// The command is held in the input register until the result register is free or
// drains; the result register then loads and offers the result beat. The link of
// the stack head is kept in a register; after a pop the link RAM is read at the new head
// and its registered read data is forwarded to the next command, so back-to-back pops
// run at full rate. The link RAM needs no clearing after reset. The user writes the slot
// limit through cfg_we_i/cfg_wdata_i only while the block is idle, which is not enforced.
`include "assert_macros.svh"

module free_list_slot_allocator_core #(
  parameter int unsigned POOL_SLOTS = fsa_pkg::POOL_SLOTS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // tdata: cmd [2:0], slot_in [12:3], zero pad [15:13]
  input  logic [fsa_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: slot_out [9:0], status [11:10], live_count [22:12],
  //        fresh_count [33:23], zero pad [39:34]
  output logic [fsa_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  input  logic                                 cfg_we_i,
  input  logic [fsa_pkg::CNT_W-1:0]            cfg_wdata_i
);

  localparam int unsigned SLOT_W     = fsa_pkg::SLOT_W;
  localparam int unsigned CNT_W      = fsa_pkg::CNT_W;
  localparam int unsigned LINK_DEPTH = (POOL_SLOTS < (1 << SLOT_W)) ? POOL_SLOTS
                                                                    : (1 << SLOT_W);
  localparam int unsigned AW         = $clog2(LINK_DEPTH);
  localparam int unsigned LIVE_W     = $clog2(POOL_SLOTS + 1);
  localparam int unsigned PAD_W      = fsa_pkg::OUT_TDATA_W - SLOT_W
                                       - fsa_pkg::STATUS_W - 2 * CNT_W;

  // Input register
  logic                      in_vld_q;
  fsa_pkg::cmd_e             in_cmd_q;
  logic [SLOT_W-1:0]         in_slot_q;

  // Allocator state
  logic [CNT_W-1:0]          limit_q;
  logic [SLOT_W-1:0]         head_q, head_d;
  logic                      empty_q, empty_d;
  logic [CNT_W-1:0]          bump_q, bump_d;
  logic [LIVE_W-1:0]         live_q, live_d;
  logic [CNT_W-1:0]          walk_q, walk_d;
  logic [SLOT_W-1:0]         head_link_q, head_link_d;
  logic                      fetch_q;

  // Result register
  logic                      out_vld_q;
  logic [SLOT_W-1:0]         res_slot_q, res_slot_d;
  fsa_pkg::status_e          res_status_q, res_status_d;
  logic [CNT_W-1:0]          res_live_q;
  logic [CNT_W-1:0]          res_fresh_q;

  // Link RAM
  logic                      ram_we, ram_re;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [SLOT_W-1:0]         ram_wdata, ram_rdata;

  logic                      proc;
  logic [SLOT_W-1:0]         head_link;
  logic                      slot_ok;
  logic                      live_can_inc;
  logic                      fresh_ok;

  // Advance the command when the result register is free or drains this cycle.
  assign proc            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || proc;

  // Forward the link read issued by the previous pop.
  assign head_link    = fetch_q ? ram_rdata : head_link_q;
  assign slot_ok      = 32'(in_slot_q) < 32'(POOL_SLOTS);
  assign live_can_inc = 32'(live_q) < 32'(POOL_SLOTS);
  assign fresh_ok     = (bump_q < limit_q) && (32'(bump_q) < 32'(POOL_SLOTS));

  always_comb begin
    head_d       = head_q;
    empty_d      = empty_q;
    bump_d       = bump_q;
    live_d       = live_q;
    walk_d       = walk_q;
    head_link_d  = head_link;
    res_slot_d   = '0;
    res_status_d = fsa_pkg::ST_OK;
    ram_we       = 1'b0;
    ram_waddr    = in_slot_q[AW-1:0];
    ram_wdata    = empty_q ? in_slot_q : head_q;
    ram_re       = 1'b0;
    ram_raddr    = head_link[AW-1:0];
    if (proc) begin
      unique case (in_cmd_q)
        fsa_pkg::CMD_ALLOC: begin
          if (!empty_q && (32'(head_q) < 32'(POOL_SLOTS))) begin
            res_slot_d = head_q;
            if ((head_link == head_q) || (32'(head_link) >= 32'(POOL_SLOTS))) begin
              empty_d = 1'b1;
              head_d  = '0;
            end else begin
              // Pop: fetch the link of the new head for the next pop.
              head_d = head_link;
              ram_re = 1'b1;
            end
            if (live_can_inc) begin
              live_d = live_q + 1'b1;
            end
          end else if (fresh_ok) begin
            res_slot_d = bump_q[SLOT_W-1:0];
            bump_d     = bump_q + 1'b1;
            if (live_can_inc) begin
              live_d = live_q + 1'b1;
            end
          end else begin
            res_status_d = fsa_pkg::ST_OUT_OF_SLOTS;
          end
        end
        fsa_pkg::CMD_FREE: begin
          if (slot_ok) begin
            // Push: the new head's link is the value written, so hold it locally.
            ram_we      = 1'b1;
            head_link_d = ram_wdata;
            head_d      = in_slot_q;
            empty_d     = 1'b0;
            if (live_q != '0) begin
              live_d = live_q - 1'b1;
            end
          end
        end
        fsa_pkg::CMD_RESTART: begin
          head_d  = '0;
          empty_d = 1'b1;
          bump_d  = '0;
          live_d  = '0;
          walk_d  = '0;
        end
        fsa_pkg::CMD_WALK_INIT: begin
          walk_d = '0;
        end
        fsa_pkg::CMD_WALK_NEXT: begin
          if (walk_q >= bump_q) begin
            res_status_d = fsa_pkg::ST_WALK_END;
          end else begin
            res_slot_d = walk_q[SLOT_W-1:0];
            walk_d     = walk_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      limit_q   <= fsa_pkg::LIMIT_RST;
      head_q    <= '0;
      empty_q   <= 1'b1;
      bump_q    <= '0;
      live_q    <= '0;
      walk_q    <= '0;
      fetch_q   <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (proc) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      head_q  <= head_d;
      empty_q <= empty_d;
      bump_q  <= bump_d;
      live_q  <= live_d;
      walk_q  <= walk_d;
      fetch_q <= ram_re;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    head_link_q <= head_link_d;
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_cmd_q  <= fsa_pkg::cmd_e'(s_axis_tdata_i[fsa_pkg::CMD_W-1:0]);
      in_slot_q <= s_axis_tdata_i[fsa_pkg::CMD_W +: SLOT_W];
    end
    if (proc) begin
      res_slot_q   <= res_slot_d;
      res_status_q <= res_status_d;
      res_live_q   <= CNT_W'(live_d);
      res_fresh_q  <= bump_d;
    end
  end

  fsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {PAD_W'(0), res_fresh_q, res_live_q, res_status_q, res_slot_q};

  `FSA_NEVER(a_walk_le_bump, walk_q > bump_q, "traversal pointer passed bump pointer")
  `FSA_NEVER(a_bump_le_pool, 32'(bump_q) > 32'(POOL_SLOTS), "bump pointer beyond pool")
  `FSA_NEVER(a_ram_one_port, ram_we && ram_re, "link RAM read and write in one cycle")
  `FSA_ASSERT(a_head_in_pool, !empty_q |-> (32'(head_q) < 32'(POOL_SLOTS)), "head outside pool")

endmodule

// ----- test/slot_result_checker.sv -----
// Result checker for the free-list slot allocator: tracks the allocator state and compares
// every result beat with the oldest predicted one.
// Depends on fsa_pkg.
`timescale 1ns / 100ps

module slot_result_checker
  import fsa_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [IN_TDATA_W-1:0]  cmd_tdata_i,
  input  logic                   cmd_tvalid_i,
  input  logic                   cmd_tready_i,
  input  logic [OUT_TDATA_W-1:0] res_tdata_i,
  input  logic                   res_tvalid_i,
  input  logic                   res_tready_i,
  input  logic                   cfg_we_i,
  input  logic [CNT_W-1:0]       cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     out_of_slots_o,
  output int                     walk_ends_o
);

  localparam int unsigned POOL = POOL_SLOTS_DEF;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_e           status;
    logic [CNT_W-1:0]  live;
    logic [CNT_W-1:0]  fresh;
  } slot_result_t;

  // Shadow copy of the allocator state.
  logic [SLOT_W-1:0] link_mem [POOL];
  logic [SLOT_W-1:0] stack_top;
  logic              stack_empty;
  logic [CNT_W-1:0]  bump_ptr;
  logic [CNT_W-1:0]  live_slots;
  logic [CNT_W-1:0]  walk_ptr;
  logic [CNT_W-1:0]  slot_limit;

  slot_result_t pending_slot_results [$];
  int fail_count   = 0;
  int results_seen = 0;
  int oos_seen     = 0;
  int walk_ends    = 0;

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    fail_count++;
    if (fail_count <= 40)
      $display("[%0t] result beat %0d: %s expected %0d, got %0d", $realtime, results_seen,
               what, want, got);
  endtask

  // Advance the shadow state by one command and queue the result it must produce.
  task automatic predict_slot_result(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
    slot_result_t     r;
    logic [CNT_W-1:0] cap;
    logic [SLOT_W-1:0] nxt;
    r.slot   = '0;
    r.status = ST_OK;
    cap      = (slot_limit > CNT_W'(POOL)) ? CNT_W'(POOL) : slot_limit;
    case (cmd)
      CMD_ALLOC: begin
        if (!stack_empty) begin
          nxt    = link_mem[stack_top];
          r.slot = stack_top;
          if (nxt == stack_top) begin
            stack_empty = 1'b1;
            stack_top   = '0;
          end else begin
            stack_top = nxt;
          end
          if (live_slots < CNT_W'(POOL)) live_slots++;
        end else if (bump_ptr < cap) begin
          r.slot = bump_ptr[SLOT_W-1:0];
          bump_ptr++;
          if (live_slots < CNT_W'(POOL)) live_slots++;
        end else begin
          r.status = ST_OUT_OF_SLOTS;
        end
      end
      CMD_FREE: begin
        link_mem[slot] = stack_empty ? slot : stack_top;
        stack_top      = slot;
        stack_empty    = 1'b0;
        if (live_slots > 0) live_slots--;
      end
      CMD_RESTART: begin
        stack_top   = '0;
        stack_empty = 1'b1;
        bump_ptr    = '0;
        live_slots  = '0;
        walk_ptr    = '0;
      end
      CMD_WALK_INIT: walk_ptr = '0;
      CMD_WALK_NEXT: begin
        if (walk_ptr >= bump_ptr) begin
          r.status = ST_WALK_END;
        end else begin
          r.slot = walk_ptr[SLOT_W-1:0];
          walk_ptr++;
        end
      end
      default: ;
    endcase
    r.live  = live_slots;
    r.fresh = bump_ptr;
    if (r.status == ST_OUT_OF_SLOTS) oos_seen++;
    if (r.status == ST_WALK_END) walk_ends++;
    pending_slot_results.push_back(r);
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] beat);
    slot_result_t want;
    if (pending_slot_results.size() == 0) begin
      report_mismatch("beat with nothing pending, slot_out", '0, beat[9:0]);
      results_seen++;
      return;
    end
    want = pending_slot_results.pop_front();
    if (beat[9:0] !== want.slot)    report_mismatch("slot_out", want.slot, beat[9:0]);
    if (beat[11:10] !== want.status) report_mismatch("status", want.status, beat[11:10]);
    if (beat[22:12] !== want.live)  report_mismatch("live_count", want.live, beat[22:12]);
    if (beat[33:23] !== want.fresh) report_mismatch("fresh_count", want.fresh, beat[33:23]);
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_top   = '0;
      stack_empty = 1'b1;
      bump_ptr    = '0;
      live_slots  = '0;
      walk_ptr    = '0;
      slot_limit  = LIMIT_RST;
      pending_slot_results.delete();
    end else begin
      if (cfg_we_i) slot_limit = cfg_wdata_i;
      if (res_tvalid_i && res_tready_i) check_result(res_tdata_i);
      if (cmd_tvalid_i && cmd_tready_i) predict_slot_result(cmd_tdata_i[2:0], cmd_tdata_i[12:3]);
    end
    fail_count_o   <= fail_count;
    pending_o      <= pending_slot_results.size();
    results_o      <= results_seen;
    out_of_slots_o <= oos_seen;
    walk_ends_o    <= walk_ends;
  end

endmodule

// ----- test/tb.sv -----
// Top of the slot allocator testbench: clock, reset, command stimulus, result-side stalls
// and the verdict. Depends on fsa_pkg, free_list_slot_allocator_core and slot_result_checker.
`timescale 1ns / 100ps

module tb;
  import fsa_pkg::*;

  // Command codes the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
  localparam int               IDLE_LIMIT    = 2000;
  localparam int               PHASE_ITEMS   = 62;
  localparam int               PHASES        = 8;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic [IN_TDATA_W-1:0]  cmd_tdata = '0;
  logic                   cmd_tvalid = 1'b0;
  logic                   cmd_tready;
  logic [OUT_TDATA_W-1:0] res_tdata;
  logic                   res_tvalid;
  logic                   res_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;

  int fail_count, pending, results, out_of_slots, walk_ends;
  int commands_sent = 0;
  int limit_writes  = 0;
  int idle_cycles   = 0;
  int stall_left    = 0;
  bit calm          = 1'b0;   // no idling on either side while set
  logic [SLOT_W-1:0] last_freed = '0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  free_list_slot_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (cmd_tdata),
    .s_axis_tvalid_i (cmd_tvalid),
    .s_axis_tready_o (cmd_tready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tvalid_o (res_tvalid),
    .m_axis_tready_i (res_tready),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  slot_result_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_tdata_i    (cmd_tdata),
    .cmd_tvalid_i   (cmd_tvalid),
    .cmd_tready_i   (cmd_tready),
    .res_tdata_i    (res_tdata),
    .res_tvalid_i   (res_tvalid),
    .res_tready_i   (res_tready),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results),
    .out_of_slots_o (out_of_slots),
    .walk_ends_o    (walk_ends)
  );

  // Idle stretch length: mostly short, now and then long.
  function automatic int idle_span();
    return ($urandom_range(0, 99) < 88) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  // Result side: drop tready for random stretches unless the phase runs calm.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      res_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 22) begin
      stall_left <= idle_span() - 1;
      res_tready <= 1'b0;
    end else begin
      res_tready <= 1'b1;
    end
  end

  // Watchdog: give up when beats stop moving while work is outstanding.
  always @(posedge clk_i) begin
    if ((cmd_tvalid && cmd_tready) || (res_tvalid && res_tready) ||
        (!cmd_tvalid && pending == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("free_list_slot_allocator_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Send one command beat; an optional gap goes in front so that a back-to-back beat
  // keeps tvalid high without a second assignment in the accept step.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [SLOT_W-1:0] slot);
    int gap;
    gap = (calm || $urandom_range(0, 99) >= 35) ? 0 : idle_span();
    if (gap > 0) begin
      cmd_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_tdata  <= {3'b000, slot, cmd};
    cmd_tvalid <= 1'b1;
    do @(posedge clk_i); while (!cmd_tready);
    commands_sent++;
    if (cmd == CMD_FREE) last_freed = slot;
  endtask

  // Hold off the sender until every predicted result has come back.
  task automatic settle_results();
    cmd_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_slot_limit(input logic [CNT_W-1:0] value);
    settle_results();
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    limit_writes++;
  endtask

  // One random command: mostly alloc/free traffic on low slots, some traversal,
  // occasional restart, double free and ignored codes.
  task automatic send_random_command();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 42)
      send_command(CMD_ALLOC, SLOT_W'($urandom_range(0, 1023)));
    else if (pick < 72)
      send_command(CMD_FREE, ($urandom_range(0, 9) < 7) ? SLOT_W'($urandom_range(0, 63))
                                                         : SLOT_W'($urandom_range(0, 1023)));
    else if (pick < 84)
      send_command(CMD_WALK_NEXT, SLOT_W'($urandom_range(0, 1023)));
    else if (pick < 89)
      send_command(CMD_WALK_INIT, SLOT_W'($urandom_range(0, 1023)));
    else if (pick < 93)
      send_command(CMD_RESTART, SLOT_W'($urandom_range(0, 1023)));
    else if (pick < 96)
      send_command(CMD_FREE, last_freed);
    else
      send_command(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                   SLOT_W'($urandom_range(0, 1023)));
  endtask

  initial begin
    logic [CNT_W-1:0] phase_limit;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero limit refuses fresh slots.
    write_slot_limit(11'd0);
    send_command(CMD_ALLOC, '0);
    // Limit above the pool size behaves as the pool size.
    write_slot_limit(11'd2047);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, 10'd1);
    send_command(CMD_FREE, 10'd1);       // double free on top: self-link drops the rest
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);         // stack empty again, back to the bump pointer
    send_command(CMD_FREE, 10'd1023);    // bottom of stack links to itself
    send_command(CMD_FREE, 10'd0);
    send_command(CMD_ALLOC, 10'h3ff);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_WALK_INIT, '0);
    repeat (5) send_command(CMD_WALK_NEXT, '0);
    send_command(CMD_WALK_NEXT, 10'h3ff); // keeps ending past the bump pointer
    send_command(CMD_UNUSED_LO, 10'h2aa);
    send_command(CMD_UNUSED_LO + 3'd1, 10'h155);
    send_command(CMD_UNUSED_HI, 10'h3ff);
    send_command(CMD_RESTART, '0);
    send_command(CMD_FREE, 10'd512);     // free with nothing live: pushed, count stays 0
    send_command(CMD_ALLOC, '0);
    send_command(CMD_WALK_NEXT, '0);
    write_slot_limit(11'd1);
    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '0);

    // Exhaust a small limit: three pops, then twelve fresh slots, then refusals.
    write_slot_limit(11'd12);
    send_command(CMD_RESTART, '0);
    send_command(CMD_FREE, 10'd5);
    send_command(CMD_FREE, 10'd700);
    send_command(CMD_FREE, 10'd1010);
    repeat (18) send_command(CMD_ALLOC, '0);

    // Random phases under varied limits; the first lowers the limit below the bump pointer.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       phase_limit = 11'd4;
        1:       phase_limit = 11'd1024;
        2:       phase_limit = 11'd2047;
        3:       phase_limit = 11'd1;
        4:       phase_limit = 11'd0;
        5:       phase_limit = CNT_W'($urandom_range(2, 60));
        6:       phase_limit = 11'd1000;
        default: phase_limit = CNT_W'($urandom_range(0, 2047));
      endcase
      write_slot_limit(phase_limit);
      calm = (ph == 2);
      if (ph != 0 && $urandom_range(0, 1) == 1) send_command(CMD_RESTART, '0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 1 && k == 30) settle_results();
        send_random_command();
      end
    end
    calm = 1'b0;

    settle_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d command beats across %0d slot limit settings", commands_sent,
             limit_writes);
    $display("checked %0d results, %0d refused allocations, %0d traversal ends", results,
             out_of_slots, walk_ends);
    if (fail_count == 0) begin
      $display("free_list_slot_allocator_core: match");
    end else begin
      $display("free_list_slot_allocator_core: mismatch");
    end
    $finish;
  end

endmodule
